// File: src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int FRAC_BITS = 30;
	localparam int DATA_W    = 32;
	localparam int RATIO_W   = 20;
	localparam int S_W       = DATA_W + 2;          // diagonal sums
	localparam int RAD_W     = 2 * DATA_W - 2;      // square root radicand
	localparam int ROOT_W    = RAD_W / 2;           // square root result
	localparam int MAG_W     = FRAC_BITS + 1;       // magnitude, 0 .. one
	localparam int SQ_W      = 2 * FRAC_BITS + 1;   // square of a magnitude
	localparam int ISQ_LAT   = ROOT_W;              // one root bit per stage

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(11529);
	localparam logic [2:0]         ADDR_RATIO  = 3'd0;

	typedef struct packed {
		logic signed [DATA_W-1:0] col1_x;
		logic signed [DATA_W-1:0] col1_y;
		logic signed [DATA_W-1:0] col1_z;
		logic signed [DATA_W-1:0] col2_y;
		logic signed [DATA_W-1:0] col2_z;
		logic signed [DATA_W-1:0] col3_x;
		logic signed [DATA_W-1:0] col3_y;
		logic signed [DATA_W-1:0] col3_z;
	} mat_t;

	typedef struct packed {
		logic        [DATA_W-2:0] quat_real;
		logic signed [DATA_W-1:0] quat_i;
		logic signed [DATA_W-1:0] quat_j;
		logic signed [DATA_W-1:0] quat_k;
	} quat_t;

endpackage

// File: src/rmq_isqrt.sv
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_isqrt import rmq_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]  rem_s [ROOT_W];
	logic [ROOT_W-1:0] acc_s [ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		localparam int B = ROOT_W - 1 - g;
		logic [RAD_W+1:0]  trial;
		logic [RAD_W-1:0]  rem_in;
		logic [ROOT_W-1:0] acc_in;

		if (g == 0) begin : g_first
			assign rem_in = rad;
			assign acc_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign acc_in = acc_s[g-1];
		end

		// (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
		assign trial = ((RAD_W+2)'(acc_in) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if ({2'b00, rem_in} >= trial) begin
					rem_s[g] <= rem_in - trial[RAD_W-1:0];
					acc_s[g] <= acc_in | (ROOT_W'(1) << B);
				end else begin
					rem_s[g] <= rem_in;
					acc_s[g] <= acc_in;
				end
			end
		end
	end

	assign root = acc_s[ROOT_W-1];

endmodule

// File: src/rmq_cfg.sv
// ----------------------------------------------------------------------------
// rmq_cfg
// APB register file holding the negligible ratio.
// ----------------------------------------------------------------------------
module rmq_cfg import rmq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [RATIO_W-1:0] ratio
);

	logic [RATIO_W-1:0] ratio_q;
	logic               hit;

	assign hit    = (paddr[2] == ADDR_RATIO[2]);
	assign pready = 1'b1;

	// register write on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (psel && penable && pwrite && hit) begin
			ratio_q <= pwdata[RATIO_W-1:0];
		end
	end

	assign prdata = hit ? {{(32-RATIO_W){1'b0}}, ratio_q} : 32'd0;
	assign ratio  = ratio_q;

endmodule

// File: src/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Fixed point rotation matrix to unit quaternion conversion.
//
// Input channel (mat_valid, mat_stall, mat) takes eight matrix entries in
// signed Q1.30; output channel (quat_valid, quat_stall, quat) returns the
// scalar and three vector parts. One result beat per input beat, in order.
// Throughput: one beat per cycle while no result waits under quat_stall.
// Data passes two 31-stage square root pipelines (vector magnitudes, then
// the scalar) plus square, sum, maximum, threshold multiply and output stages.
// The pipeline moves as one: while a result beat waits under quat_stall,
// every stage holds and mat_stall is raised; nothing is lost or repeated.
// Reset clears all valid bits and loads the ratio register (APB, address 0)
// with its default; data registers are not reset. The user must write the
// ratio register only while the pipeline holds no beat; the core does not enforce it.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        mat_valid,
	output logic        mat_stall,
	input  mat_t        mat,
	output logic        quat_valid,
	input  logic        quat_stall,
	output quat_t       quat,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PIPE_LAT = 2 * ISQ_LAT + 9;
	localparam logic signed [S_W-1:0] ONE_S   = S_W'(1) <<< FRAC_BITS;
	localparam logic [MAG_W-1:0]      ONE_M   = MAG_W'(1) << FRAC_BITS;
	localparam logic [RAD_W-1:0]      FULL_SQ = RAD_W'(1) << (2 * FRAC_BITS);

	typedef struct packed {
		logic [2:0]                neg;
		logic [3:0][MAG_W-1:0]     mag;
		logic [3:0][SQ_W-1:0]      sq;
	} side_t;

	logic               en;
	logic [RATIO_W-1:0] ratio;
	logic [PIPE_LAT-1:0] vld_q;

	assign en         = !(quat_valid && quat_stall);
	assign mat_stall  = quat_valid && quat_stall;
	assign quat_valid = vld_q[PIPE_LAT-1];

	rmq_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .ratio
	);

	// valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], mat_valid};
		end
	end

	// stage 1: diagonal sums, radicands and sign flags
	logic signed [S_W-1:0] sum_i, sum_j, sum_k;
	logic signed [DATA_W:0] d_i, d_j, d_k;
	logic [2:0][RAD_W-1:0] rad_s1;
	logic [2:0]            neg_s1;

	function automatic logic signed [S_W-1:0] sx(input logic signed [DATA_W-1:0] v);
		return S_W'(v);
	endfunction

	function automatic logic [RAD_W-1:0] to_rad(input logic signed [S_W-1:0] s);
		logic [RAD_W-1:0] r;
		r = '0;
		if (s > 0) r = {s, (FRAC_BITS - 2)'(0)};
		return r;
	endfunction

	assign sum_i = ONE_S + sx(mat.col1_x) - sx(mat.col2_y) - sx(mat.col3_z);
	assign sum_j = ONE_S - sx(mat.col1_x) + sx(mat.col2_y) - sx(mat.col3_z);
	assign sum_k = ONE_S - sx(mat.col1_x) - sx(mat.col2_y) + sx(mat.col3_z);
	assign d_i   = (DATA_W+1)'(mat.col2_z) - (DATA_W+1)'(mat.col3_y);
	assign d_j   = (DATA_W+1)'(mat.col3_x) - (DATA_W+1)'(mat.col1_z);
	assign d_k   = (DATA_W+1)'(mat.col1_y) - (DATA_W+1)'(mat.col2_z);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1[0] <= to_rad(sum_i);
			rad_s1[1] <= to_rad(sum_j);
			rad_s1[2] <= to_rad(sum_k);
			neg_s1    <= {d_k[DATA_W], d_j[DATA_W], d_i[DATA_W]};
		end
	end

	// vector magnitude roots
	logic [2:0][ROOT_W-1:0] root_v;
	logic [2:0]             neg_dly_q [ISQ_LAT];

	for (genvar c = 0; c < 3; c++) begin : g_vec
		rmq_isqrt u_isqrt (.clk, .en, .rad(rad_s1[c]), .root(root_v[c]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_dly_q[0] <= neg_s1;
			for (int t = 1; t < ISQ_LAT; t++) neg_dly_q[t] <= neg_dly_q[t-1];
		end
	end

	// stages 2..4: clamp, square, scalar radicand
	side_t            side_s2, side_s3, side_s4;
	side_t            side_n2, side_n3;
	logic [RAD_W-1:0] rad_s4;
	logic [RAD_W-1:0] sq_sum;
	logic [2*MAG_W-1:0] prod_v [3];

	assign sq_sum = RAD_W'(side_s3.sq[1]) + RAD_W'(side_s3.sq[2]) + RAD_W'(side_s3.sq[3]);

	for (genvar c = 0; c < 3; c++) begin : g_sq
		assign prod_v[c] = side_s2.mag[c+1] * side_s2.mag[c+1];
	end

	// next values of stages 2 and 3
	always_comb begin
		side_n2     = '0;
		side_n2.neg = neg_dly_q[ISQ_LAT-1];
		for (int c = 0; c < 3; c++) begin
			side_n2.mag[c+1] = (root_v[c] > ROOT_W'(ONE_M)) ? ONE_M
			                                                : root_v[c][MAG_W-1:0];
		end
		side_n3 = side_s2;
		for (int c = 0; c < 3; c++) side_n3.sq[c+1] = prod_v[c][SQ_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_n2;
			side_s3 <= side_n3;
			side_s4 <= side_s3;
			rad_s4  <= (sq_sum <= FULL_SQ) ? (FULL_SQ - sq_sum) : '0;
		end
	end

	// scalar root
	logic [ROOT_W-1:0] root_r;
	side_t             side_dly_q [ISQ_LAT];

	rmq_isqrt u_isqrt_r (.clk, .en, .rad(rad_s4), .root(root_r));

	always_ff @(posedge clk) begin
		if (en) begin
			side_dly_q[0] <= side_s4;
			for (int t = 1; t < ISQ_LAT; t++) side_dly_q[t] <= side_dly_q[t-1];
		end
	end

	// stages 5..9: scalar square, maximum, threshold, zeroing and signs
	side_t              side_s5, side_s6, side_s7, side_s8;
	side_t              side_n5, side_n6;
	logic [2*MAG_W-1:0] prod_r;
	logic [SQ_W-1:0]    max_s6;
	logic [SQ_W-1:0]    mx01, mx23;
	logic [31+RATIO_W:0]         lo_s7;
	logic [SQ_W-33+RATIO_W:0]    hi_s7;
	logic [SQ_W-32+RATIO_W:0]    msum;
	logic [SQ_W-32+RATIO_W-28:0] thr_s8;
	logic                        frac;
	quat_t                       quat_s9;

	assign prod_r = side_s5.mag[0] * side_s5.mag[0];
	assign mx01   = (side_s5.sq[1] > prod_r[SQ_W-1:0]) ? side_s5.sq[1] : prod_r[SQ_W-1:0];
	assign mx23   = (side_s5.sq[3] > side_s5.sq[2]) ? side_s5.sq[3] : side_s5.sq[2];
	assign msum   = (SQ_W-31+RATIO_W)'(hi_s7) + (SQ_W-31+RATIO_W)'(lo_s7 >> 32);
	assign frac   = (|msum[27:0]) || (|lo_s7[31:0]);

	// next values of stages 5 and 6
	always_comb begin
		side_n5        = side_dly_q[ISQ_LAT-1];
		side_n5.mag[0] = root_r[MAG_W-1:0];
		side_n6        = side_s5;
		side_n6.sq[0]  = prod_r[SQ_W-1:0];
	end

	function automatic logic signed [DATA_W-1:0] signed_mag(input logic [MAG_W-1:0] m,
	                                                        input logic neg);
		logic signed [DATA_W-1:0] v;
		v = DATA_W'(m);
		return neg ? -v : v;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_n5;
			// square of the scalar and the largest square
			side_s6 <= side_n6;
			max_s6  <= (mx01 > mx23) ? mx01 : mx23;
			// split product max * ratio
			side_s7 <= side_s6;
			lo_s7   <= max_s6[31:0] * ratio;
			hi_s7   <= max_s6[SQ_W-1:32] * ratio;
			// ceiling of max * ratio / 2^60
			side_s8 <= side_s7;
			thr_s8  <= msum[SQ_W-32+RATIO_W:28] + (SQ_W-32+RATIO_W-27)'(frac);
			// zero small parts, apply signs
			quat_s9.quat_real <= (side_s8.sq[0] < SQ_W'(thr_s8)) ? '0 : side_s8.mag[0];
			quat_s9.quat_i <= (side_s8.sq[1] < SQ_W'(thr_s8)) ? '0
			                : signed_mag(side_s8.mag[1], side_s8.neg[0]);
			quat_s9.quat_j <= (side_s8.sq[2] < SQ_W'(thr_s8)) ? '0
			                : signed_mag(side_s8.mag[2], side_s8.neg[1]);
			quat_s9.quat_k <= (side_s8.sq[3] < SQ_W'(thr_s8)) ? '0
			                : signed_mag(side_s8.mag[3], side_s8.neg[2]);
		end
	end

	assign quat = quat_s9;

endmodule
